### hw/rtl/fsts_pkg.sv
// Shared types, codes, constants and the nice-to-weight table for the fair-share scheduler.
`timescale 1ns / 1ps

package fsts_pkg;

   localparam logic [2:0] CMD_ENQUEUE = 3'd0;
   localparam logic [2:0] CMD_ACCOUNT = 3'd1;
   localparam logic [2:0] CMD_SLICE   = 3'd2;
   localparam logic [2:0] CMD_PICK    = 3'd3;
   localparam logic [2:0] CMD_BALANCE = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_BAD_TASK = 3'd2;
   localparam logic [2:0] ST_BAD_CORE = 3'd3;
   localparam logic [2:0] ST_NO_TASK  = 3'd4;

   localparam int DIV_DVD_W = 42;
   localparam int DIV_DSR_W = 32;
   localparam int DIV_CNT_W = 6;

   localparam logic [63:0] MIN_SLICE   = 64'd1000000;
   localparam logic [63:0] TARGET_SPAN = 64'd6000000;

   localparam logic [16:0] WEIGHT_TABLE [40] = '{
      17'd88761, 17'd71755, 17'd56483, 17'd46273, 17'd36291,
      17'd29154, 17'd23254, 17'd18705, 17'd14949, 17'd11916,
      17'd9548,  17'd7620,  17'd6100,  17'd4904,  17'd3906,
      17'd3121,  17'd2501,  17'd1991,  17'd1586,  17'd1277,
      17'd1024,  17'd820,   17'd655,   17'd526,   17'd423,
      17'd335,   17'd272,   17'd215,   17'd172,   17'd137,
      17'd110,   17'd87,    17'd70,    17'd56,    17'd45,
      17'd36,    17'd29,    17'd23,    17'd18,    17'd15
   };

   typedef enum logic [4:0] {
      UOP_NONE,
      UOP_LOAD,
      UOP_SCAN_INIT,
      UOP_SCAN,
      UOP_TAKE_LOW,
      UOP_READ_LEFT,
      UOP_ENQ_WRITE,
      UOP_READ_TASK,
      UOP_DIV_ACC,
      UOP_ACC_WRITE,
      UOP_SLICE_MUL,
      UOP_SLICE_SPAN,
      UOP_DIV_SLICE,
      UOP_SLICE_DONE,
      UOP_PICK,
      UOP_BALANCE,
      UOP_FAIL_FULL,
      UOP_FAIL_TASK,
      UOP_FAIL_CORE,
      UOP_FAIL_EMPTY,
      UOP_EMIT
   } uop_type;

   typedef struct packed {
      uop_type uop;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       full;
      logic       bad_core;
      logic       bad_task;
      logic       no_task;
      logic       scan_last;
      logic       slice_empty;
      logic       div_done;
      logic       out_free;
   } dp_status_type;

   function automatic logic [16:0] nice_weight(input logic [5:0] nice);
      logic signed [6:0] wi;
      logic [5:0]        ix;
      begin
         wi = $signed({nice[5], nice}) + 7'sd20;
         if (wi < 7'sd0) begin
            ix = 6'd0;
         end else if (wi > 7'sd39) begin
            ix = 6'd39;
         end else begin
            ix = wi[5:0];
         end
         return WEIGHT_TABLE[ix];
      end
   endfunction

endpackage

### hw/rtl/fsts_divider.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fsts_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [fsts_pkg::DIV_DVD_W-1:0]  dividend,
   input  logic [fsts_pkg::DIV_DSR_W-1:0]  divisor,
   output logic [fsts_pkg::DIV_DVD_W-1:0]  quotient,
   output logic                            done
);
   import fsts_pkg::*;

   logic [DIV_DVD_W-1:0] dq_ff;
   logic [DIV_DSR_W-1:0] rem_ff;
   logic [DIV_DSR_W-1:0] dsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_DSR_W:0]   trial;
   logic [DIV_DSR_W:0]   diff;
   logic                 ge;

   assign trial = {rem_ff, dq_ff[DIV_DVD_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = (trial >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dq_ff   <= dividend;
            rem_ff  <= '0;
            dsr_ff  <= divisor;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            dq_ff  <= {dq_ff[DIV_DVD_W-2:0], ge};
            rem_ff <= ge ? diff[DIV_DSR_W-1:0] : trial[DIV_DSR_W-1:0];
            cnt_ff <= cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient = dq_ff;
   assign done     = done_ff;

endmodule

### hw/rtl/fsts_datapath.sv
// Datapath of the scheduler: task tables, core records, divider, result and output registers.
`timescale 1ns / 1ps

module fsts_datapath #(
   parameter int TASK_DEPTH = 256,
   parameter int CORE_DEPTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fsts_pkg::ctrl_cmd_type  cmd,
   output fsts_pkg::dp_status_type status,
   input  logic                    csr_wr_en,
   input  logic [3:0]              csr_wr_data,
   input  logic [2:0]              req_command,
   input  logic signed [5:0]       req_nice_level,
   input  logic [5:0]              req_core,
   input  logic [7:0]              req_task_index,
   input  logic [31:0]             req_run_time,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic [7:0]              rsp_assigned_index,
   output logic [2:0]              rsp_source_core,
   output logic [2:0]              rsp_dest_core,
   output logic                    rsp_moved,
   output logic [63:0]             rsp_value
);
   import fsts_pkg::*;

   localparam int TIW = $clog2(TASK_DEPTH);
   localparam int TCW = $clog2(TASK_DEPTH + 1);
   localparam int CW  = (CORE_DEPTH > 1) ? $clog2(CORE_DEPTH) : 1;
   localparam int LW  = TCW + 1;

   uop_type uop;

   logic [2:0]        op_ff;
   logic [16:0]       weight_ff;
   logic [5:0]        core_req_ff;
   logic [7:0]        tix_ff;
   logic [31:0]       run_ff;
   logic [3:0]        active_ff;
   logic [TCW-1:0]    total_ff;
   logic [TCW-1:0]    count_ff [CORE_DEPTH];
   logic [31:0]       wsum_ff  [CORE_DEPTH];
   logic [63:0]       floor_ff [CORE_DEPTH];
   logic [TIW:0]      left_ff  [CORE_DEPTH];
   logic [CW-1:0]     csel_ff;
   logic [CW-1:0]     hi_ff;
   logic [CW-1:0]     lo_ff;
   logic [LW-1:0]     hiload_ff;
   logic [LW-1:0]     loload_ff;
   logic [41:0]       prod_ff;

   logic [16:0]       mem_weight [TASK_DEPTH];
   logic [63:0]       mem_vtime  [TASK_DEPTH];
   logic [CW-1:0]     mem_core   [TASK_DEPTH];
   logic [16:0]       rd_weight_ff;
   logic [63:0]       rd_vtime_ff;
   logic [CW-1:0]     rd_core_ff;

   logic [2:0]        res_status_ff;
   logic [7:0]        res_assigned_ff;
   logic [2:0]        res_src_ff;
   logic [2:0]        res_dst_ff;
   logic              res_moved_ff;
   logic [63:0]       res_value_ff;

   logic              rsp_valid_ff;
   logic [2:0]        rsp_status_ff;
   logic [7:0]        rsp_assigned_ff;
   logic [2:0]        rsp_src_ff;
   logic [2:0]        rsp_dst_ff;
   logic              rsp_moved_ff;
   logic [63:0]       rsp_value_ff;

   logic [TIW-1:0]    tidx;
   logic [TIW-1:0]    nidx;
   logic [TIW-1:0]    rd_addr;
   logic [LW-1:0]     scan_load;
   logic [63:0]       vt_new;
   logic              vt_we;
   logic [TIW-1:0]    vt_waddr;
   logic [63:0]       vt_wdata;
   logic              bal_ok;
   logic              csr_ok;
   logic              div_start;
   logic [41:0]       div_dividend;
   logic [31:0]       div_divisor;
   logic [41:0]       div_q;
   logic              div_done;

   assign uop       = cmd.uop;
   assign tidx      = TIW'(tix_ff);
   assign nidx      = total_ff[TIW-1:0];
   assign rd_addr   = (uop == UOP_READ_LEFT) ? left_ff[csel_ff][TIW-1:0] : tidx;
   assign scan_load = LW'(count_ff[csel_ff]);
   assign vt_new    = rd_vtime_ff + 64'(div_q);
   assign bal_ok    = (hiload_ff >= loload_ff) && ((hiload_ff - loload_ff) >= LW'(2))
                      && (hiload_ff > LW'(1));
   assign csr_ok    = (csr_wr_data != 4'd0) && (32'(csr_wr_data) <= 32'(CORE_DEPTH));

   assign div_start    = (uop == UOP_DIV_ACC) || (uop == UOP_DIV_SLICE);
   assign div_dividend = (uop == UOP_DIV_ACC) ? {run_ff, 10'b0} : prod_ff;
   assign div_divisor  = (uop == UOP_DIV_ACC) ? 32'(rd_weight_ff) : wsum_ff[csel_ff];

   fsts_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_q),
      .done     (div_done)
   );

   always_comb begin
      vt_we    = 1'b0;
      vt_waddr = nidx;
      vt_wdata = floor_ff[csel_ff];
      if (uop == UOP_ENQ_WRITE) begin
         vt_we = 1'b1;
      end else if (uop == UOP_ACC_WRITE) begin
         vt_we    = 1'b1;
         vt_waddr = tidx;
         vt_wdata = vt_new;
      end
   end

   always_ff @(posedge clock) begin
      if ((uop == UOP_READ_LEFT) || (uop == UOP_READ_TASK)) begin
         rd_weight_ff <= mem_weight[rd_addr];
         rd_vtime_ff  <= mem_vtime[rd_addr];
         rd_core_ff   <= mem_core[rd_addr];
      end
      if (uop == UOP_ENQ_WRITE) begin
         mem_weight[nidx] <= weight_ff;
         mem_core[nidx]   <= csel_ff;
      end
      if (vt_we) begin
         mem_vtime[vt_waddr] <= vt_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 4'd1;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CORE_DEPTH; i++) begin
            count_ff[i] <= '0;
            wsum_ff[i]  <= '0;
            floor_ff[i] <= '0;
            left_ff[i]  <= '1;
         end
      end else begin
         if (uop == UOP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            if (csr_ok) begin
               active_ff <= csr_wr_data;
               total_ff  <= '0;
               for (int i = 0; i < CORE_DEPTH; i++) begin
                  count_ff[i] <= '0;
                  wsum_ff[i]  <= '0;
                  floor_ff[i] <= '0;
                  left_ff[i]  <= '1;
               end
            end
         end else begin
            unique case (uop)
               UOP_LOAD: begin
                  op_ff           <= req_command;
                  weight_ff       <= nice_weight(req_nice_level);
                  core_req_ff     <= req_core;
                  tix_ff          <= req_task_index;
                  run_ff          <= req_run_time;
                  csel_ff         <= CW'(req_core);
                  res_status_ff   <= ST_OK;
                  res_assigned_ff <= '0;
                  res_src_ff      <= '0;
                  res_dst_ff      <= '0;
                  res_moved_ff    <= 1'b0;
                  res_value_ff    <= '0;
               end
               UOP_SCAN_INIT: begin
                  csel_ff   <= '0;
                  hi_ff     <= '0;
                  lo_ff     <= '0;
                  hiload_ff <= '0;
                  loload_ff <= '1;
               end
               UOP_SCAN: begin
                  if (scan_load > hiload_ff) begin
                     hiload_ff <= scan_load;
                     hi_ff     <= csel_ff;
                  end
                  if (scan_load < loload_ff) begin
                     loload_ff <= scan_load;
                     lo_ff     <= csel_ff;
                  end
                  csel_ff <= csel_ff + CW'(1);
               end
               UOP_TAKE_LOW: begin
                  csel_ff <= lo_ff;
               end
               UOP_ENQ_WRITE: begin
                  count_ff[csel_ff] <= count_ff[csel_ff] + TCW'(1);
                  wsum_ff[csel_ff]  <= wsum_ff[csel_ff] + 32'(weight_ff);
                  if (left_ff[csel_ff][TIW] || (floor_ff[csel_ff] <= rd_vtime_ff)) begin
                     left_ff[csel_ff] <= {1'b0, nidx};
                  end
                  total_ff        <= total_ff + TCW'(1);
                  res_assigned_ff <= 8'(nidx);
                  res_src_ff      <= 3'(csel_ff);
               end
               UOP_DIV_ACC: begin
                  csel_ff <= rd_core_ff;
               end
               UOP_ACC_WRITE: begin
                  if (vt_new > floor_ff[csel_ff]) begin
                     floor_ff[csel_ff] <= vt_new;
                  end
                  res_value_ff <= vt_new;
               end
               UOP_SLICE_MUL: begin
                  csel_ff <= rd_core_ff;
                  prod_ff <= 42'(rd_weight_ff) * 42'(TARGET_SPAN);
               end
               UOP_SLICE_SPAN: begin
                  res_value_ff <= TARGET_SPAN;
               end
               UOP_SLICE_DONE: begin
                  res_value_ff <= (64'(div_q) < MIN_SLICE) ? MIN_SLICE : 64'(div_q);
               end
               UOP_PICK: begin
                  res_assigned_ff <= 8'(left_ff[csel_ff][TIW-1:0]);
               end
               UOP_BALANCE: begin
                  res_src_ff <= 3'(hi_ff);
                  res_dst_ff <= 3'(lo_ff);
                  if (bal_ok) begin
                     count_ff[hi_ff] <= TCW'(hiload_ff - LW'(1));
                     count_ff[lo_ff] <= TCW'(loload_ff + LW'(1));
                     res_moved_ff    <= 1'b1;
                  end
               end
               UOP_FAIL_FULL: begin
                  res_status_ff <= ST_FULL;
               end
               UOP_FAIL_TASK: begin
                  res_status_ff <= ST_BAD_TASK;
                  if (op_ff == CMD_SLICE) begin
                     res_value_ff <= MIN_SLICE;
                  end
               end
               UOP_FAIL_CORE: begin
                  res_status_ff <= ST_BAD_CORE;
               end
               UOP_FAIL_EMPTY: begin
                  res_status_ff <= ST_NO_TASK;
               end
               UOP_EMIT: begin
                  rsp_status_ff   <= res_status_ff;
                  rsp_assigned_ff <= res_assigned_ff;
                  rsp_src_ff      <= res_src_ff;
                  rsp_dst_ff      <= res_dst_ff;
                  rsp_moved_ff    <= res_moved_ff;
                  rsp_value_ff    <= res_value_ff;
               end
               UOP_NONE, UOP_READ_LEFT, UOP_READ_TASK, UOP_DIV_SLICE: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      status.op          = op_ff;
      status.full        = (total_ff == TCW'(TASK_DEPTH));
      status.bad_core    = (core_req_ff >= {2'b00, active_ff});
      status.bad_task    = (32'(tix_ff) >= 32'(total_ff));
      status.no_task     = left_ff[csel_ff][TIW];
      status.scan_last   = (8'(csel_ff) == (8'(active_ff) - 8'd1));
      status.slice_empty = (count_ff[csel_ff] == '0) || (wsum_ff[csel_ff] == '0);
      status.div_done    = div_done;
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_assigned_index = rsp_assigned_ff;
   assign rsp_source_core    = rsp_src_ff;
   assign rsp_dest_core      = rsp_dst_ff;
   assign rsp_moved          = rsp_moved_ff;
   assign rsp_value          = rsp_value_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(uop == UOP_EMIT))
      else $error("Response word appeared without an emit.");

   a_enq_counts: assert property (@(posedge clock) disable iff (reset)
      (uop == UOP_ENQ_WRITE) && !csr_wr_en |=> total_ff == $past(total_ff) + TCW'(1))
      else $error("Enqueue did not advance the task count.");

   a_div_result: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !div_done)
      else $error("Divider finished in the cycle after start.");

endmodule

### hw/rtl/fsts_ctrl.sv
// Controller state machine that sequences each scheduler command through the datapath.
`timescale 1ns / 1ps

module fsts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  fsts_pkg::dp_status_type status,
   output fsts_pkg::ctrl_cmd_type  cmd
);
   import fsts_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN_INIT,
      S_SCAN,
      S_TAKE_LOW,
      S_ENQ_READ,
      S_ENQ_WRITE,
      S_TASK_READ,
      S_ACC_DIV,
      S_DIV_WAIT,
      S_ACC_WRITE,
      S_SLICE_MUL,
      S_SLICE_CHECK,
      S_SLICE_SPAN,
      S_SLICE_DIV,
      S_SLICE_DONE,
      S_PICK,
      S_BALANCE,
      S_FAIL_FULL,
      S_FAIL_TASK,
      S_FAIL_CORE,
      S_FAIL_EMPTY,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            priority case (status.op)
               CMD_ENQUEUE: begin
                  if (status.full) state_in = S_FAIL_FULL;
                  else if (status.bad_core) state_in = S_SCAN_INIT;
                  else state_in = S_ENQ_READ;
               end
               CMD_ACCOUNT, CMD_SLICE: begin
                  state_in = status.bad_task ? S_FAIL_TASK : S_TASK_READ;
               end
               CMD_PICK: begin
                  if (status.bad_core) state_in = S_FAIL_CORE;
                  else if (status.no_task) state_in = S_FAIL_EMPTY;
                  else state_in = S_PICK;
               end
               CMD_BALANCE: state_in = S_SCAN_INIT;
               default: state_in = S_FINISH;
            endcase
         end
         S_SCAN_INIT: state_in = S_SCAN;
         S_SCAN: begin
            if (status.scan_last) begin
               state_in = (status.op == CMD_ENQUEUE) ? S_TAKE_LOW : S_BALANCE;
            end
         end
         S_TAKE_LOW:  state_in = S_ENQ_READ;
         S_ENQ_READ:  state_in = S_ENQ_WRITE;
         S_TASK_READ: state_in = (status.op == CMD_ACCOUNT) ? S_ACC_DIV : S_SLICE_MUL;
         S_ACC_DIV:   state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = (status.op == CMD_ACCOUNT) ? S_ACC_WRITE : S_SLICE_DONE;
            end
         end
         S_SLICE_MUL:   state_in = S_SLICE_CHECK;
         S_SLICE_CHECK: state_in = status.slice_empty ? S_SLICE_SPAN : S_SLICE_DIV;
         S_SLICE_DIV:   state_in = S_DIV_WAIT;
         S_ENQ_WRITE, S_ACC_WRITE, S_SLICE_SPAN, S_SLICE_DONE, S_PICK, S_BALANCE,
         S_FAIL_FULL, S_FAIL_TASK, S_FAIL_CORE, S_FAIL_EMPTY: state_in = S_FINISH;
         S_FINISH: begin
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.uop = UOP_NONE;
      unique case (state_ff)
         S_IDLE:        cmd.uop = req_valid ? UOP_LOAD : UOP_NONE;
         S_SCAN_INIT:   cmd.uop = UOP_SCAN_INIT;
         S_SCAN:        cmd.uop = UOP_SCAN;
         S_TAKE_LOW:    cmd.uop = UOP_TAKE_LOW;
         S_ENQ_READ:    cmd.uop = UOP_READ_LEFT;
         S_ENQ_WRITE:   cmd.uop = UOP_ENQ_WRITE;
         S_TASK_READ:   cmd.uop = UOP_READ_TASK;
         S_ACC_DIV:     cmd.uop = UOP_DIV_ACC;
         S_ACC_WRITE:   cmd.uop = UOP_ACC_WRITE;
         S_SLICE_MUL:   cmd.uop = UOP_SLICE_MUL;
         S_SLICE_SPAN:  cmd.uop = UOP_SLICE_SPAN;
         S_SLICE_DIV:   cmd.uop = UOP_DIV_SLICE;
         S_SLICE_DONE:  cmd.uop = UOP_SLICE_DONE;
         S_PICK:        cmd.uop = UOP_PICK;
         S_BALANCE:     cmd.uop = UOP_BALANCE;
         S_FAIL_FULL:   cmd.uop = UOP_FAIL_FULL;
         S_FAIL_TASK:   cmd.uop = UOP_FAIL_TASK;
         S_FAIL_CORE:   cmd.uop = UOP_FAIL_CORE;
         S_FAIL_EMPTY:  cmd.uop = UOP_FAIL_EMPTY;
         S_FINISH:      cmd.uop = status.out_free ? UOP_EMIT : UOP_NONE;
         S_DISPATCH, S_DIV_WAIT, S_SLICE_CHECK: cmd.uop = UOP_NONE;
         default:       cmd.uop = UOP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign req_stall = busy_ff;

endmodule

### hw/rtl/fair_share_task_scheduler_top.sv
// Enqueue scans every active core to choose the least loaded one when the requested core is
// out of range; balance scans every active core; account and slice on a valid task wait on
// the 42-step divider, except a slice on an empty core. One command is handled at a time;
// the next word can be taken in the cycle after the result is registered. Reset (synchronous):
// active cores 1, task count and core records cleared.
`timescale 1ns / 1ps

module fair_share_task_scheduler_top #(
   parameter int TASK_DEPTH = 256,
   parameter int CORE_DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [3:0]        csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_command,
   input  logic signed [5:0] req_nice_level,
   input  logic [5:0]        req_core,
   input  logic [7:0]        req_task_index,
   input  logic [31:0]       req_run_time,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_assigned_index,
   output logic [2:0]        rsp_source_core,
   output logic [2:0]        rsp_dest_core,
   output logic              rsp_moved,
   output logic [63:0]       rsp_value
);
   import fsts_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   fsts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fsts_datapath #(
      .TASK_DEPTH (TASK_DEPTH),
      .CORE_DEPTH (CORE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_command        (req_command),
      .req_nice_level     (req_nice_level),
      .req_core           (req_core),
      .req_task_index     (req_task_index),
      .req_run_time       (req_run_time),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_assigned_index (rsp_assigned_index),
      .rsp_source_core    (rsp_source_core),
      .rsp_dest_core      (rsp_dest_core),
      .rsp_moved          (rsp_moved),
      .rsp_value          (rsp_value)
   );

endmodule

### test/testbench.sv
// Self-checking testbench for the fair-share task scheduler: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
   import fsts_pkg::*;

   localparam int TASKS = 256;
   localparam int CORES = 8;
   localparam int EMPTY_LEFT = 511;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [2:0]  status;
      logic [7:0]  index;
      logic [2:0]  src;
      logic [2:0]  dst;
      logic        moved;
      logic [63:0] value;
   } outcome_type;

   typedef struct {
      logic [2:0]  cmd;
      logic [5:0]  nice;
      logic [5:0]  core;
      logic [7:0]  tix;
      logic [31:0] run;
      bit          typed;
      outcome_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [3:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_command = '0;
   logic signed [5:0] req_nice_level = '0;
   logic [5:0] req_core = '0;
   logic [7:0] req_task_index = '0;
   logic [31:0] req_run_time = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [7:0] rsp_assigned_index;
   logic [2:0] rsp_source_core;
   logic [2:0] rsp_dest_core;
   logic rsp_moved;
   logic [63:0] rsp_value;

   logic [16:0] t_weight [TASKS];
   logic [63:0] t_vtime [TASKS];
   int t_core [TASKS];
   int total;
   int active_cores;
   int c_count [CORES];
   logic [31:0] c_wsum [CORES];
   logic [63:0] c_floor [CORES];
   int c_left [CORES];

   outcome_type outcome_q [$];
   int errors = 0;
   int cycles = 0;
   bit calm = 1'b0;

   fair_share_task_scheduler_top dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_nice_level(req_nice_level),
      .req_core(req_core), .req_task_index(req_task_index),
      .req_run_time(req_run_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_assigned_index(rsp_assigned_index),
      .rsp_source_core(rsp_source_core), .rsp_dest_core(rsp_dest_core),
      .rsp_moved(rsp_moved), .rsp_value(rsp_value)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 15);
   end

   function automatic void clear_cores();
      total = 0;
      for (int i = 0; i < CORES; i++) begin
         c_count[i] = 0;
         c_wsum[i] = '0;
         c_floor[i] = '0;
         c_left[i] = EMPTY_LEFT;
      end
   endfunction

   function automatic void apply_active_cores(input logic [3:0] v);
      if (v != 0 && v <= CORES) begin
         active_cores = v;
         clear_cores();
      end
   endfunction

   function automatic int least_loaded();
      int best = 0;
      int load = 32'h7fffffff;
      for (int i = 0; i < active_cores; i++) begin
         if (c_count[i] < load) begin
            load = c_count[i];
            best = i;
         end
      end
      return best;
   endfunction

   function automatic outcome_type scheduler_outcome(input logic [2:0] cmd,
      input logic signed [5:0] nice, input logic [5:0] core_in,
      input logic [7:0] tix, input logic [31:0] run);
      outcome_type r;
      int wi, idx, c, hi, lo, hiload, loload;
      logic [63:0] s;
      r = '{default: '0};
      c = core_in;
      case (cmd)
         CMD_ENQUEUE: begin
            if (total >= TASKS) begin
               r.status = ST_FULL;
            end else begin
               wi = int'(nice) + 20;
               if (wi < 0) wi = 0;
               if (wi > 39) wi = 39;
               if (c >= active_cores) c = least_loaded();
               idx = total;
               t_weight[idx] = WEIGHT_TABLE[wi];
               t_vtime[idx] = c_floor[c];
               t_core[idx] = c;
               c_count[c]++;
               c_wsum[c] += t_weight[idx];
               if (c_left[c] >= TASKS || t_vtime[idx] <= t_vtime[c_left[c]]) c_left[c] = idx;
               total++;
               r.index = 8'(idx);
               r.src = 3'(c);
            end
         end
         CMD_ACCOUNT: begin
            if (tix >= total) begin
               r.status = ST_BAD_TASK;
            end else begin
               c = t_core[tix];
               t_vtime[tix] += (64'(run) * 64'd1024) / 64'(t_weight[tix]);
               if (t_vtime[tix] > c_floor[c]) c_floor[c] = t_vtime[tix];
               r.value = t_vtime[tix];
            end
         end
         CMD_SLICE: begin
            if (tix >= total) begin
               r.status = ST_BAD_TASK;
               r.value = MIN_SLICE;
            end else begin
               c = t_core[tix];
               if (c_count[c] == 0 || c_wsum[c] == 0) begin
                  r.value = TARGET_SPAN;
               end else begin
                  s = (64'(t_weight[tix]) * TARGET_SPAN) / 64'(c_wsum[c]);
                  r.value = (s < MIN_SLICE) ? MIN_SLICE : s;
               end
            end
         end
         CMD_PICK: begin
            if (c >= active_cores) r.status = ST_BAD_CORE;
            else if (c_left[c] >= TASKS) r.status = ST_NO_TASK;
            else r.index = 8'(c_left[c]);
         end
         CMD_BALANCE: begin
            hi = 0;
            lo = 0;
            hiload = 0;
            loload = 32'h7fffffff;
            for (int i = 0; i < active_cores; i++) begin
               if (c_count[i] > hiload) begin
                  hiload = c_count[i];
                  hi = i;
               end
               if (c_count[i] < loload) begin
                  loload = c_count[i];
                  lo = i;
               end
            end
            if (hiload >= loload && hiload - loload >= 2 && c_count[hi] > 1) begin
               c_count[hi]--;
               c_count[lo]++;
               r.moved = 1'b1;
            end
            r.src = 3'(hi);
            r.dst = 3'(lo);
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_q.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            w = outcome_q.pop_front();
            if (rsp_status !== w.status) begin
               $error("status: expected %0d, got %0d", w.status, rsp_status);
               errors++;
            end
            if (rsp_assigned_index !== w.index) begin
               $error("assigned_index: expected %0d, got %0d", w.index, rsp_assigned_index);
               errors++;
            end
            if (rsp_source_core !== w.src) begin
               $error("source_core: expected %0d, got %0d", w.src, rsp_source_core);
               errors++;
            end
            if (rsp_dest_core !== w.dst) begin
               $error("dest_core: expected %0d, got %0d", w.dst, rsp_dest_core);
               errors++;
            end
            if (rsp_moved !== w.moved) begin
               $error("moved: expected %0d, got %0d", w.moved, rsp_moved);
               errors++;
            end
            if (rsp_value !== w.value) begin
               $error("value: expected %0d, got %0d", w.value, rsp_value);
               errors++;
            end
         end
      end
   end

   task automatic send_word(input row_type row);
      outcome_type predicted;
      if (!calm && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= row.cmd;
      req_nice_level <= row.nice;
      req_core <= row.core;
      req_task_index <= row.tix;
      req_run_time <= row.run;
      do @(posedge clock); while (req_stall);
      predicted = scheduler_outcome(row.cmd, row.nice, row.core, row.tix, row.run);
      outcome_q.push_back(row.typed ? row.want : predicted);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_active_cores(input logic [3:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      apply_active_cores(v);
      @(posedge clock);
   endtask

   function automatic row_type random_row(input int enq_pct);
      row_type r;
      int pick;
      r.typed = 1'b0;
      r.want = '{default: '0};
      r.nice = 6'($urandom);
      r.run = $urandom;
      r.core = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, active_cores - 1));
      r.tix = (total == 0 || $urandom_range(0, 9) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, total - 1));
      pick = $urandom_range(0, 99);
      if (pick < enq_pct) r.cmd = CMD_ENQUEUE;
      else if (pick >= 97) r.cmd = 3'($urandom_range(5, 7));
      else r.cmd = 3'($urandom_range(1, 4));
      if ($urandom_range(0, 3) == 0) r.run = $urandom_range(0, 2000);
      return r;
   endfunction

   initial begin
      row_type rows [$];
      outcome_type z;
      row_type r;
      int sent;
      int n;
      int enq_pct;
      logic [3:0] cfg;

      z = '{default: '0};
      active_cores = 1;
      clear_cores();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows.push_back('{CMD_PICK, 6'd0, 6'd0, 8'd0, 32'd0, 1'b1,
                       '{ST_NO_TASK, 8'd0, 3'd0, 3'd0, 1'b0, 64'd0}});
      rows.push_back('{CMD_PICK, 6'd0, 6'd63, 8'd0, 32'd0, 1'b1,
                       '{ST_BAD_CORE, 8'd0, 3'd0, 3'd0, 1'b0, 64'd0}});
      rows.push_back('{CMD_ACCOUNT, 6'd0, 6'd0, 8'd0, 32'hffffffff, 1'b1,
                       '{ST_BAD_TASK, 8'd0, 3'd0, 3'd0, 1'b0, 64'd0}});
      rows.push_back('{CMD_SLICE, 6'd0, 6'd0, 8'd255, 32'd0, 1'b1,
                       '{ST_BAD_TASK, 8'd0, 3'd0, 3'd0, 1'b0, MIN_SLICE}});
      rows.push_back('{CMD_BALANCE, 6'd0, 6'd0, 8'd0, 32'd0, 1'b1, z});
      rows.push_back('{3'd5, 6'h3f, 6'h3f, 8'hff, 32'hffffffff, 1'b1, z});
      rows.push_back('{3'd6, 6'd0, 6'd0, 8'd0, 32'd0, 1'b1, z});
      rows.push_back('{3'd7, 6'h15, 6'h2a, 8'h55, 32'haaaaaaaa, 1'b1, z});
      rows.push_back('{CMD_ENQUEUE, 6'h20, 6'd0, 8'd0, 32'd0, 1'b1,
                       '{ST_OK, 8'd0, 3'd0, 3'd0, 1'b0, 64'd0}});
      rows.push_back('{CMD_ENQUEUE, 6'h1f, 6'd63, 8'd0, 32'd0, 1'b1,
                       '{ST_OK, 8'd1, 3'd0, 3'd0, 1'b0, 64'd0}});
      rows.push_back('{CMD_ENQUEUE, 6'h2c, 6'd0, 8'd0, 32'd0, 1'b0, z});
      rows.push_back('{CMD_ENQUEUE, 6'h13, 6'd5, 8'd0, 32'd0, 1'b0, z});
      rows.push_back('{CMD_ACCOUNT, 6'd0, 6'd0, 8'd0, 32'hffffffff, 1'b0, z});
      rows.push_back('{CMD_ACCOUNT, 6'd0, 6'd0, 8'd1, 32'hffffffff, 1'b0, z});
      rows.push_back('{CMD_ACCOUNT, 6'd0, 6'd0, 8'd2, 32'd0, 1'b0, z});
      rows.push_back('{CMD_SLICE, 6'd0, 6'd0, 8'd0, 32'd0, 1'b0, z});
      rows.push_back('{CMD_SLICE, 6'd0, 6'd0, 8'd1, 32'd0, 1'b0, z});
      rows.push_back('{CMD_ENQUEUE, 6'd0, 6'd0, 8'd0, 32'd0, 1'b0, z});
      rows.push_back('{CMD_PICK, 6'd0, 6'd0, 8'd0, 32'd0, 1'b0, z});
      rows.push_back('{CMD_BALANCE, 6'd0, 6'd0, 8'd0, 32'd0, 1'b0, z});
      foreach (rows[i]) send_word(rows[i]);
      drain();

      sent = rows.size();
      while (sent < 1950) begin
         case ($urandom_range(0, 5))
            0: cfg = 4'd1;
            1: cfg = 4'd8;
            2: cfg = 4'($urandom_range(9, 15));
            3: cfg = 4'd0;
            default: cfg = 4'($urandom_range(1, 8));
         endcase
         write_active_cores(cfg);
         if ($urandom_range(0, 4) == 0) begin
            n = 300;
            enq_pct = 92;
         end else begin
            n = $urandom_range(60, 200);
            enq_pct = $urandom_range(20, 50);
         end
         for (int k = 0; k < n && sent < 1950; k++) begin
            calm = (sent >= 700 && sent < 1000);
            r = random_row(enq_pct);
            send_word(r);
            sent++;
         end
         drain();
      end
      calm = 1'b0;

      if (errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
